[rtl/core/bbt_pkg.sv]
// shared types and constants for the byte budget eviction table
`default_nettype none
package bbt_pkg;
    localparam int ENTRIES     = 32;
    localparam int SLOT_W      = 5;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int KEY_W       = 32;
    localparam int SIZE_W      = 32;
    localparam int CHARGE_W    = 33;
    localparam int STAMP_W     = 64;
    localparam int USAGE_W     = 40;
    localparam logic [USAGE_W-1:0] BUDGET_RESET = 40'd2147483648;
    localparam logic [CHARGE_W-1:0] STAMP_BYTES = 33'd8;

    localparam logic [1:0] OP_SET     = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_ENFORCE = 2'd3;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic do_set;
        logic do_clear;
        logic do_evict;
        logic emit;
        logic emit_evict;
        logic emit_last;
    } bbt_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       scan_done;
        logic       found;
        logic       free_found;
        logic       any_valid;
        logic       over_budget;
    } bbt_sts_t;
endpackage
`default_nettype wire

[rtl/core/bbt_datapath.sv]
// table storage, sequential key and oldest-stamp scan, charge accounting
`default_nettype none
module bbt_datapath import bbt_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bbt_cmd_t            cmd,
    output bbt_sts_t                 sts,
    input  wire logic [1:0]          op,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [SIZE_W-1:0]   record_size,
    input  wire logic [USAGE_W-1:0]  budget,
    output logic                     res_valid,
    output logic                     res_hit,
    output logic [SLOT_W-1:0]        res_slot,
    output logic                     res_evicted,
    output logic [KEY_W-1:0]         res_evicted_key,
    output logic                     res_full_error,
    output logic [USAGE_W-1:0]       res_usage,
    output logic                     res_last
);
    logic [ENTRIES-1:0]   valid_reg;
    logic [KEY_W-1:0]     key_mem [ENTRIES];
    logic [CHARGE_W-1:0]  charge_mem [ENTRIES];
    logic [STAMP_W-1:0]   stamp_mem [ENTRIES];
    logic [STAMP_W-1:0]   counter_reg;
    logic [USAGE_W-1:0]   total_reg;
    logic [1:0]           op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 found_reg;
    logic [SLOT_W-1:0]    found_slot_reg;
    logic                 free_reg;
    logic [SLOT_W-1:0]    free_slot_reg;
    logic                 best_reg;
    logic [SLOT_W-1:0]    best_slot_reg;
    logic [STAMP_W-1:0]   best_stamp_reg;
    logic [KEY_W-1:0]     best_key_reg;
    logic [CHARGE_W-1:0]  best_charge_reg;
    logic [CHARGE_W-1:0]  found_charge_reg;
    logic [SLOT_W-1:0]    idx;
    logic                 v;
    logic [SLOT_W-1:0]    set_slot;
    logic [CHARGE_W-1:0]  new_charge;
    logic [USAGE_W-1:0]   set_total;

    assign idx = idx_reg[SLOT_W-1:0];
    assign v   = valid_reg[idx];
    assign set_slot   = found_reg ? found_slot_reg : free_slot_reg;
    assign new_charge = {1'b0, size_reg} + STAMP_BYTES;
    assign set_total  = (found_reg ? total_reg - USAGE_W'(found_charge_reg) : total_reg)
                        + USAGE_W'(new_charge);

    always_comb
    begin
        sts.op          = op_reg;
        sts.scan_done   = idx_reg == CNT_W'(ENTRIES);
        sts.found       = found_reg;
        sts.free_found  = free_reg;
        sts.any_valid   = |valid_reg;
        sts.over_budget = total_reg > budget;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            if (v && (!best_reg || stamp_mem[idx] < best_stamp_reg))
            begin
                best_slot_reg   <= idx;
                best_stamp_reg  <= stamp_mem[idx];
                best_key_reg    <= key_mem[idx];
                best_charge_reg <= charge_mem[idx];
            end
            if (v && key_mem[idx] == key_reg && !found_reg)
            begin
                found_slot_reg   <= idx;
                found_charge_reg <= charge_mem[idx];
            end
            if (!v && !free_reg)
                free_slot_reg <= idx;
        end
        if (cmd.do_set)
        begin
            key_mem[set_slot]    <= key_reg;
            charge_mem[set_slot] <= new_charge;
            stamp_mem[set_slot]  <= counter_reg + STAMP_W'(1);
        end
        if (cmd.load)
        begin
            op_reg   <= op;
            key_reg  <= key;
            size_reg <= record_size;
        end
        res_hit         <= 1'b0;
        res_slot        <= '0;
        res_evicted     <= 1'b0;
        res_evicted_key <= '0;
        res_full_error  <= 1'b0;
        res_last        <= cmd.emit_last;
        if (cmd.emit_evict)
        begin
            res_evicted     <= 1'b1;
            res_slot        <= best_slot_reg;
            res_evicted_key <= best_key_reg;
        end
        else if (cmd.emit && op_reg == OP_QUERY && found_reg)
        begin
            res_hit  <= 1'b1;
            res_slot <= found_slot_reg;
        end
        else if (cmd.emit && op_reg == OP_SET)
        begin
            if (found_reg || free_reg)
            begin
                res_hit  <= found_reg;
                res_slot <= set_slot;
            end
            else
                res_full_error <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            counter_reg <= STAMP_W'(1);
            total_reg   <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            best_reg    <= 1'b0;
            res_valid   <= 1'b0;
            res_usage   <= '0;
        end
        else
        begin
            res_valid <= cmd.emit;
            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
                best_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
                if (v)
                    best_reg <= 1'b1;
                if (v && key_mem[idx] == key_reg)
                    found_reg <= 1'b1;
                if (!v)
                    free_reg <= 1'b1;
            end
            if (cmd.do_set)
            begin
                valid_reg[set_slot] <= 1'b1;
                counter_reg         <= counter_reg + STAMP_W'(1);
                total_reg           <= set_total;
                res_usage           <= set_total;
            end
            else if (cmd.do_clear)
            begin
                valid_reg <= '0;
                total_reg <= '0;
                res_usage <= '0;
            end
            else if (cmd.do_evict)
            begin
                valid_reg[best_slot_reg] <= 1'b0;
                total_reg <= total_reg - USAGE_W'(best_charge_reg);
                res_usage <= total_reg - USAGE_W'(best_charge_reg);
            end
            else if (cmd.emit)
                res_usage <= total_reg;
        end
    end
endmodule
`default_nettype wire

[rtl/core/bbt_ctrl.sv]
// controller state machine sequencing scans, updates and results
`default_nettype none
module bbt_ctrl import bbt_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire bbt_sts_t sts,
    output bbt_cmd_t      cmd,
    output logic          busy
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_ESCAN = 3'd4;
    localparam logic [2:0] S_EVICT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [CNT_W-1:0] nev_reg, nev_next;

    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        nev_next   = nev_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    nev_next       = '0;
                    state_next     = S_SCAN;
                end
            S_SCAN:
                if (sts.op == OP_CLEAR || sts.op == OP_ENFORCE)
                    state_next = S_EXEC;
                else if (sts.scan_done)
                    state_next = S_EXEC;
                else
                    cmd.scan_step = 1'b1;
            S_EXEC:
            begin
                if (sts.op == OP_ENFORCE)
                    state_next = S_CHECK;
                else
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.do_clear  = sts.op == OP_CLEAR;
                    cmd.do_set    = sts.op == OP_SET && (sts.found || sts.free_found);
                    state_next    = S_IDLE;
                end
            end
            S_CHECK:
                if (sts.over_budget && sts.any_valid && nev_reg != CNT_W'(ENTRIES))
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_ESCAN;
                end
                else
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            S_ESCAN:
                if (sts.scan_done)
                    state_next = S_EVICT;
                else
                    cmd.scan_step = 1'b1;
            S_EVICT:
            begin
                cmd.do_evict   = 1'b1;
                cmd.emit       = 1'b1;
                cmd.emit_evict = 1'b1;
                nev_next       = nev_reg + CNT_W'(1);
                state_next     = S_CHECK;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nev_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nev_reg   <= nev_next;
        end
    end
endmodule
`default_nettype wire

[rtl/core/byte_budget_oldest_write_evict_table_unit.sv]
// top level of the byte budget oldest-write eviction table
//
// usage: pulse start with op, key and record_size while busy is low; the
// transaction is taken at that edge. results appear on the result ports,
// one per cycle at most, each marked by result_valid for one cycle; the
// final one of a transaction has last high. the receiver cannot stall.
// set and query scan all 32 slots, one per cycle. clear skips the scan and
// empties the table in the exec state. enforce repeats, for each eviction,
// a check, an oldest-stamp scan over the table memory and the update.
// one transaction is handled at a time. the user is to write byte_budget
// through cfg_valid/cfg_ready only while idle; the block does not enforce it;
// cfg_ready is always high. reset empties the table, sets the stamp
// counter to 1, usage to 0 and the budget to 2^31; no clearing pass.
`default_nettype none
module byte_budget_oldest_write_evict_table_unit import bbt_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          op,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [SIZE_W-1:0]   record_size,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [USAGE_W-1:0]  cfg_data,
    output logic                     result_valid,
    output logic                     hit,
    output logic [SLOT_W-1:0]        slot,
    output logic                     evicted,
    output logic [KEY_W-1:0]         evicted_key,
    output logic                     full_error,
    output logic [USAGE_W-1:0]       usage,
    output logic                     last
);
    bbt_cmd_t cmd;
    bbt_sts_t sts;
    logic [USAGE_W-1:0] budget_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            budget_reg <= BUDGET_RESET;
        else if (cfg_valid && cfg_ready)
            budget_reg <= cfg_data;
    end

    bbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bbt_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .op              (op),
        .key             (key),
        .record_size     (record_size),
        .budget          (budget_reg),
        .res_valid       (result_valid),
        .res_hit         (hit),
        .res_slot        (slot),
        .res_evicted     (evicted),
        .res_evicted_key (evicted_key),
        .res_full_error  (full_error),
        .res_usage       (usage),
        .res_last        (last)
    );

`ifndef SYNTHESIS
    a_no_start_while_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result right after accept");
    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("busy after last result");
    a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && evicted) |-> !last)
        else $error("eviction marked last");
`endif
endmodule
`default_nettype wire
